>>> design/tpmv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ternary packed matrix-vector engine.
package tpmv_pkg;

    localparam int ACC_W   = 40;
    localparam int OUT_W   = 48;
    localparam int VAL_W   = 16;
    localparam int SCALE_W = 32;
    localparam int CNT_W   = 13;
    localparam int IDX_W   = 24;
    localparam int CFG_W   = 32;

    typedef enum logic [1:0] {
        KIND_VEC_WRITE = 2'd0,
        KIND_WEIGHT    = 2'd1,
        KIND_READ      = 2'd2,
        KIND_PRELOAD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_ROW_COUNT   = 2'd0,
        CFG_COL_COUNT   = 2'd1,
        CFG_SCALE       = 2'd2,
        CFG_TRANSPOSED  = 2'd3
    } cfg_index_t;

    localparam logic [1:0] CODE_NEG = 2'b00;
    localparam logic [1:0] CODE_POS = 2'b10;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_WSEL  = 11'b00000000100,
        S_DIV   = 11'b00000001000,
        S_VRD   = 11'b00000010000,
        S_ARD   = 11'b00000100000,
        S_RRD   = 11'b00001000000,
        S_RMUL  = 11'b00010000000,
        S_RSUM  = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_NEXT  = 11'b10000000000
    } state_t;

endpackage

>>> design/ternary_packed_matvec_engine.sv
`timescale 1ns / 1ps
// Top level: sequencer around the vector and accumulator memories.
//
//  channel | signals                                   | handshake
//  input   | kind entry_index vector_value weight_byte | in_valid / in_ready
//          | byte_address preload_value                |
//  output  | result_value is_read_data saturated       | out_valid / out_ready
//  config  | cfg_index cfg_data                        | cfg_we, no wait
//
// Vector write and preload go straight to S_OUT; a read passes S_RRD, and also
// S_RMUL and S_RSUM when it is scaled. A weight byte visits S_WSEL for each of
// its four weights; one that is zero or outside the matrix goes to S_NEXT, a
// used one passes S_DIV, where the bit-serial divider splits the weight index
// into row and column, then S_VRD and S_ARD. After reset the whole accumulator
// memory is cleared, one entry a cycle, before the first item is taken.
// The next item is taken while a result still waits in the output register;
// its own result then holds the sequencer until that register is free.
module ternary_packed_matvec_engine
    import tpmv_pkg::*;
#(
    parameter int VEC_DEPTH = 4096,
    parameter int ACC_DEPTH = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              kind,
    input  logic [11:0]             entry_index,
    input  logic signed [15:0]      vector_value,
    input  logic [7:0]              weight_byte,
    input  logic [21:0]             byte_address,
    input  logic signed [39:0]      preload_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [47:0]      result_value,
    output logic                    is_read_data,
    output logic                    saturated,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int VEC_AW = $clog2(VEC_DEPTH);
    localparam int ACC_AW = $clog2(ACC_DEPTH);
    localparam logic signed [ACC_W+1:0] ACC_MAX = 42'sd549755813887;
    localparam logic signed [ACC_W+1:0] ACC_MIN = -42'sd549755813888;
    localparam logic signed [57:0] OUT_MAX = 58'sd140737488355327;
    localparam logic signed [57:0] OUT_MIN = -58'sd140737488355328;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         row_reg, col_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    logic                     mode_reg;

    logic [ACC_AW-1:0]        clr_reg, clr_next;
    logic [1:0]               k_reg, k_next;
    logic [7:0]               wb_reg, wb_next;
    logic [21:0]              a_reg, a_next;
    logic [11:0]              ei_reg, ei_next;
    logic [1:0]               code_reg, code_next;
    logic [IDX_W-1:0]         ai_reg, ai_next;
    logic                     sat_reg, sat_next;
    logic                     rd_reg, rd_next;
    logic signed [OUT_W-1:0]  res_reg, res_next;
    logic signed [VAL_W-1:0]  v_reg, v_next;
    logic signed [47:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]  accv_reg, accv_next;
    logic signed [55:0]       phi_reg, phi_next;
    logic signed [56:0]       plo_reg, plo_next;
    logic                     ov_reg, ov_next;
    logic signed [OUT_W-1:0]  ores_reg, ores_next;
    logic                     ord_reg, ord_next;
    logic                     osat_reg, osat_next;

    logic                     vec_we, acc_we;
    logic [VEC_AW-1:0]        vec_addr;
    logic [ACC_AW-1:0]        acc_addr;
    logic [VAL_W-1:0]         vec_wdata, vec_rdata;
    logic [ACC_W-1:0]         acc_wdata, acc_rdata;

    logic                     div_start;
    logic                     div_done;
    logic [IDX_W-1:0]         div_q;
    logic [CNT_W-1:0]         div_r;

    logic [IDX_W-1:0]         idx;
    logic [2*CNT_W-1:0]       total;
    logic [7:0]               wb_shift;
    logic [1:0]               code;
    logic [IDX_W-1:0]         vi, ai;
    logic signed [32:0]       add;
    logic signed [ACC_W+1:0]  sum;
    logic signed [ACC_W-1:0]  sum_clamped;
    logic                     sum_sat;
    logic signed [57:0]       rsum;
    logic                     accept;

    tpmv_ram #(.WIDTH(VAL_W), .DEPTH(VEC_DEPTH)) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .addr  (vec_addr),
        .wdata (vec_wdata),
        .rdata (vec_rdata)
    );

    tpmv_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .addr  (acc_addr),
        .wdata (acc_wdata),
        .rdata (acc_rdata)
    );

    tpmv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (idx),
        .divisor   (row_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Global index of weight k within the packed stream.
    assign idx      = {a_reg[21:5], 7'd0} + {19'd0, a_reg[4:0]} + {17'd0, k_reg, 5'd0};
    assign total    = row_reg * col_reg;
    assign wb_shift = wb_reg << {k_reg, 1'b0};
    assign code     = wb_shift[7:6];
    assign vi       = mode_reg ? {11'd0, div_r} : div_q;
    assign ai       = mode_reg ? div_q : {11'd0, div_r};

    always_comb
    begin
        if (mode_reg)
        begin
            add = 33'(v_reg);
        end
        else
        begin
            add = 33'(prod_reg >>> 16);
        end
        if (code_reg == CODE_NEG)
        begin
            add = -add;
        end
        sum = 42'($signed(acc_rdata)) + 42'(add);
        sum_sat = 1'b0;
        sum_clamped = ACC_W'(sum);
        if (sum > ACC_MAX)
        begin
            sum_clamped = ACC_W'(ACC_MAX);
            sum_sat = 1'b1;
        end
        else if (sum < ACC_MIN)
        begin
            sum_clamped = ACC_W'(ACC_MIN);
            sum_sat = 1'b1;
        end
        rsum = 58'(phi_reg) + 58'(plo_reg >>> 16);
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        k_next      = k_reg;
        wb_next     = wb_reg;
        a_next      = a_reg;
        ei_next     = ei_reg;
        code_next   = code_reg;
        ai_next     = ai_reg;
        sat_next    = sat_reg;
        rd_next     = rd_reg;
        res_next    = res_reg;
        v_next      = v_reg;
        prod_next   = prod_reg;
        accv_next   = accv_reg;
        phi_next    = phi_reg;
        plo_next    = plo_reg;
        ov_next     = ov_reg;
        ores_next   = ores_reg;
        ord_next    = ord_reg;
        osat_next   = osat_reg;
        vec_we      = 1'b0;
        vec_addr    = VEC_AW'(ei_reg);
        vec_wdata   = vector_value;
        acc_we      = 1'b0;
        acc_addr    = ACC_AW'(ai_reg);
        acc_wdata   = '0;
        div_start   = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                acc_we   = 1'b1;
                acc_addr = clr_reg;
                clr_next = clr_reg + ACC_AW'(1);
                if (clr_reg == ACC_AW'(ACC_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ei_next  = entry_index;
                    wb_next  = weight_byte;
                    a_next   = byte_address;
                    k_next   = 2'd0;
                    sat_next = 1'b0;
                    rd_next  = 1'b0;
                    res_next = '0;
                    state_next = S_OUT;
                    case (kind)
                        KIND_VEC_WRITE:
                        begin
                            vec_addr = VEC_AW'(entry_index);
                            vec_we   = (32'(entry_index) < VEC_DEPTH);
                        end
                        KIND_WEIGHT:
                        begin
                            state_next = S_WSEL;
                        end
                        KIND_READ:
                        begin
                            rd_next  = 1'b1;
                            acc_addr = ACC_AW'(entry_index);
                            if (32'(entry_index) < ACC_DEPTH)
                            begin
                                state_next = S_RRD;
                            end
                        end
                        default:
                        begin
                            acc_addr  = ACC_AW'(entry_index);
                            acc_wdata = preload_value;
                            acc_we    = (32'(entry_index) < ACC_DEPTH);
                        end
                    endcase
                end
            end
            S_WSEL:
            begin
                code_next = code;
                if ((code == CODE_NEG || code == CODE_POS) && ({2'd0, idx} < total))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_DIV:
            begin
                vec_addr = VEC_AW'(vi);
                ai_next  = ai;
                if (div_done)
                begin
                    if ((32'(vi) < VEC_DEPTH) && (32'(ai) < ACC_DEPTH))
                    begin
                        state_next = S_VRD;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_VRD:
            begin
                v_next    = $signed(vec_rdata);
                prod_next = $signed(vec_rdata) * scale_reg;
                acc_addr  = ACC_AW'(ai_reg);
                state_next = S_ARD;
            end
            S_ARD:
            begin
                acc_we    = 1'b1;
                acc_addr  = ACC_AW'(ai_reg);
                acc_wdata = sum_clamped;
                sat_next  = sat_reg | sum_sat;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WSEL;
                end
            end
            S_RRD:
            begin
                accv_next = $signed(acc_rdata);
                acc_we    = 1'b1;
                acc_addr  = ACC_AW'(ei_reg);
                acc_wdata = '0;
                if (mode_reg)
                begin
                    state_next = S_RMUL;
                end
                else
                begin
                    res_next   = OUT_W'($signed(acc_rdata));
                    state_next = S_OUT;
                end
            end
            S_RMUL:
            begin
                // Scale split into a signed high half and an unsigned low half.
                phi_next = accv_reg * $signed(scale_reg[31:16]);
                plo_next = accv_reg * $signed({1'b0, scale_reg[15:0]});
                state_next = S_RSUM;
            end
            S_RSUM:
            begin
                res_next = OUT_W'(rsum);
                if (rsum > OUT_MAX)
                begin
                    res_next = OUT_W'(OUT_MAX);
                    sat_next = 1'b1;
                end
                else if (rsum < OUT_MIN)
                begin
                    res_next = OUT_W'(OUT_MIN);
                    sat_next = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ores_next  = res_reg;
                    ord_next   = rd_reg;
                    osat_next  = sat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
            row_reg   <= 13'd128;
            col_reg   <= 13'd128;
            scale_reg <= 32'sd65536;
            mode_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT:  row_reg   <= cfg_data[CNT_W-1:0];
                    CFG_COL_COUNT:  col_reg   <= cfg_data[CNT_W-1:0];
                    CFG_SCALE:      scale_reg <= $signed(cfg_data);
                    CFG_TRANSPOSED: mode_reg  <= cfg_data[0];
                    default:        mode_reg  <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg   <= wb_next;
        a_reg    <= a_next;
        ei_reg   <= ei_next;
        code_reg <= code_next;
        ai_reg   <= ai_next;
        sat_reg  <= sat_next;
        rd_reg   <= rd_next;
        res_reg  <= res_next;
        v_reg    <= v_next;
        prod_reg <= prod_next;
        accv_reg <= accv_next;
        phi_reg  <= phi_next;
        plo_reg  <= plo_next;
        ores_reg <= ores_next;
        ord_reg  <= ord_next;
        osat_reg <= osat_next;
    end

    assign out_valid    = ov_reg;
    assign result_value = ores_reg;
    assign is_read_data = ord_reg;
    assign saturated    = osat_reg;

endmodule

>>> design/tpmv_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read.
module tpmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/tpmv_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for weight row and column.
module tpmv_div
    import tpmv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [IDX_W-1:0] quotient,
    output logic [CNT_W-1:0] remainder
);

    logic [IDX_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] d_reg, d_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[IDX_W-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 5'(IDX_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = CNT_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[IDX_W-2:0], 1'b1};
            end
            else
            begin
                r_next = CNT_W'(trial);
                q_next = {q_reg[IDX_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule
